>>> rtl/psvm_pkg.sv
`timescale 1ns / 1ps

package psvm_pkg;

  // voice table size and key range
  localparam int MAX_VOICES = 8;
  localparam int KEY_COUNT  = 64;
  localparam int LAMP_COUNT = 7;

  // fixed field widths
  localparam int ACTION_W = 2;
  localparam int KEY_W    = 6;
  localparam int FREQ_W   = 16;
  localparam int PHASE_W  = 32;
  localparam int LEVEL_W  = 8;
  localparam int ACTIVE_W = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int KEY_SPAN   = 1 << KEY_W;

  // derived widths
  localparam int CNT_W = $clog2(MAX_VOICES + 1);
  localparam int IDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOICE_AMP  = 2'd2;

  // register reset values
  localparam logic [PHASE_W-1:0] PHASE_MASK_RST = 32'd65535;
  localparam logic [PHASE_W-1:0] HALF_THR_RST   = 32'd32768;
  localparam logic [LEVEL_W-1:0] VOICE_AMP_RST  = 8'd60;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_WRAP = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_mask;
    logic [PHASE_W-1:0] half_thr;
    logic [LEVEL_W-1:0] voice_amp;
  } cfg_t;

  typedef struct packed {
    logic wr_step;
    logic tick;
    logic active;
  } cell_ctrl_t;

  typedef logic [KEY_SPAN-1:0][LAMP_COUNT-1:0] lamp_lut_t;

  // one-hot lamp per key, zero when the range index falls past the last lamp
  function automatic lamp_lut_t build_lamp_lut();
    lamp_lut_t   lut;
    int unsigned l;
    for (int k = 0; k < KEY_SPAN; k++) begin
      l = (k * LAMP_COUNT) / KEY_COUNT;
      if (l < LAMP_COUNT) begin
        lut[k] = LAMP_COUNT'(1 << l);
      end else begin
        lut[k] = '0;
      end
    end
    return lut;
  endfunction

  localparam lamp_lut_t LAMP_LUT = build_lamp_lut();

endpackage

>>> rtl/polyphonic_square_voice_mixer_top.sv
`timescale 1ns / 1ps

// polyphonic square voice mixer
// input channel: in_valid / in_stall carry one item (action, key, frequency);
//   action tick advances and mixes the live voices, clear empties the voice
//   table and turns the lamps off, add stores a voice in the next free slot
// output channel: out_valid / out_stall carry one result item per input
//   item: pwm_level, lamp_mask and active_voices after that item
// config port: cfg_we writes cfg_data into the register at cfg_index
//   (phase mask, half threshold, voice amplitude); other indexes are ignored
// tick: the sequencer walks a row of MAX_VOICES voice cells, one cell a cycle,
//   with the running mix handed from cell to cell; S_WRAP then takes the
//   complete mix from the last cell and S_DONE hands it to the output register
// clear, add and unused codes skip the walk and go straight to S_DONE
// throughput: one item at a time; in_stall stays high until the result is
//   in the output register, so no new item is taken while one is in flight
// a waiting result does not block the next item, but a further result
//   waits while out_stall holds the previous one
// reset (rst, synchronous): input stalled, empty table, phases zero, lamps
//   off, level zero, registers to their defaults, output register empty
module polyphonic_square_voice_mixer_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [psvm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psvm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [psvm_pkg::ACTION_W-1:0]      action,
  input  logic [psvm_pkg::KEY_W-1:0]         key,
  input  logic [psvm_pkg::FREQ_W-1:0]        frequency,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [psvm_pkg::LEVEL_W-1:0]       pwm_level,
  output logic [psvm_pkg::LAMP_COUNT-1:0]    lamp_mask,
  output logic [psvm_pkg::ACTIVE_W-1:0]      active_voices
);

  psvm_pkg::state_t               state;
  psvm_pkg::cfg_t                 cfg;
  logic [psvm_pkg::IDX_W-1:0]     idx;
  logic [psvm_pkg::CNT_W-1:0]     voice_count;
  logic [psvm_pkg::LAMP_COUNT-1:0] lamps;
  logic [psvm_pkg::LEVEL_W-1:0]   last_level;
  logic                           in_take;
  logic                           out_free;
  logic                           not_full;

  // running mix along the row of cells
  logic [psvm_pkg::LEVEL_W-1:0]   chain [psvm_pkg::MAX_VOICES+1];

  assign in_stall = rst | (state != psvm_pkg::S_IDLE);
  assign in_take  = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;
  assign not_full = (voice_count < psvm_pkg::CNT_W'(psvm_pkg::MAX_VOICES));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_mask <= psvm_pkg::PHASE_MASK_RST;
      cfg.half_thr   <= psvm_pkg::HALF_THR_RST;
      cfg.voice_amp  <= psvm_pkg::VOICE_AMP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        psvm_pkg::REG_PHASE_MASK: cfg.phase_mask <= cfg_data;
        psvm_pkg::REG_HALF_THR:   cfg.half_thr   <= cfg_data;
        psvm_pkg::REG_VOICE_AMP:  cfg.voice_amp  <= cfg_data[psvm_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // the row of voice cells, slot i is live while i is below the count
  assign chain[0] = '0;

  for (genvar i = 0; i < psvm_pkg::MAX_VOICES; i++) begin : g_cell
    psvm_pkg::cell_ctrl_t ctrl;

    assign ctrl.wr_step = in_take && (action == psvm_pkg::ACT_ADD) &&
                          (voice_count == psvm_pkg::CNT_W'(i));
    assign ctrl.tick    = (state == psvm_pkg::S_RUN) && (idx == psvm_pkg::IDX_W'(i));
    assign ctrl.active  = (psvm_pkg::CNT_W'(i) < voice_count);

    psvm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .cfg     (cfg),
      .step_in (frequency),
      .sum_in  (chain[i]),
      .sum_out (chain[i+1])
    );
  end

  // sequencer: apply clear and add directly, walk the cells on a tick, then hand over the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= psvm_pkg::S_IDLE;
      idx         <= '0;
      voice_count <= '0;
      lamps       <= '0;
      last_level  <= '0;
    end else begin
      case (state)
        psvm_pkg::S_IDLE: begin
          if (in_take) begin
            if (action == psvm_pkg::ACT_TICK) begin
              idx   <= '0;
              state <= psvm_pkg::S_RUN;
            end else begin
              if (action == psvm_pkg::ACT_CLEAR) begin
                voice_count <= '0;
                lamps       <= '0;
              end else if (action == psvm_pkg::ACT_ADD && not_full) begin
                voice_count <= voice_count + 1'b1;
                lamps       <= lamps | psvm_pkg::LAMP_LUT[key];
              end
              state <= psvm_pkg::S_DONE;
            end
          end
        end
        psvm_pkg::S_RUN: begin
          if (idx == psvm_pkg::IDX_W'(psvm_pkg::MAX_VOICES - 1)) begin
            state <= psvm_pkg::S_WRAP;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        psvm_pkg::S_WRAP: begin
          // the last cell holds the complete mix here
          last_level <= chain[psvm_pkg::MAX_VOICES];
          state      <= psvm_pkg::S_DONE;
        end
        psvm_pkg::S_DONE: begin
          if (out_free) begin
            state <= psvm_pkg::S_IDLE;
          end
        end
        default: state <= psvm_pkg::S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == psvm_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == psvm_pkg::S_DONE && out_free) begin
      pwm_level     <= last_level;
      lamp_mask     <= lamps;
      active_voices <= psvm_pkg::ACTIVE_W'(voice_count);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    voice_count <= psvm_pkg::CNT_W'(psvm_pkg::MAX_VOICES))
    else $error("voice count beyond table size");

  a_clear_lamps: assert property (@(posedge clk) disable iff (rst)
    in_take && action == psvm_pkg::ACT_CLEAR |=> lamps == '0 && voice_count == '0)
    else $error("clear left lamps or voices");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == psvm_pkg::S_DONE))
    else $error("result loaded outside hand-over");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    state == psvm_pkg::S_RUN && idx == psvm_pkg::IDX_W'(psvm_pkg::MAX_VOICES - 1)
    |=> state == psvm_pkg::S_WRAP)
    else $error("cell walk did not finish");

  a_count_steady_in_run: assert property (@(posedge clk) disable iff (rst)
    state == psvm_pkg::S_RUN |=> $stable(voice_count))
    else $error("voice count moved during a tick");
`endif

endmodule

>>> rtl/psvm_cell.sv
`timescale 1ns / 1ps

module psvm_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  psvm_pkg::cell_ctrl_t            ctrl,
  input  psvm_pkg::cfg_t                  cfg,
  input  logic [psvm_pkg::FREQ_W-1:0]     step_in,
  input  logic [psvm_pkg::LEVEL_W-1:0]    sum_in,
  output logic [psvm_pkg::LEVEL_W-1:0]    sum_out
);

  logic [psvm_pkg::FREQ_W-1:0]  step;
  logic [psvm_pkg::PHASE_W-1:0] phase;
  logic [psvm_pkg::PHASE_W-1:0] phase_next;
  logic                         high;
  logic                         fire;

  assign phase_next = phase + psvm_pkg::PHASE_W'(step);
  assign high       = (phase_next & cfg.phase_mask) >= cfg.half_thr;
  assign fire       = ctrl.tick & ctrl.active;

  always_ff @(posedge clk) begin
    if (ctrl.wr_step) begin
      step <= step_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (fire) begin
      phase <= phase_next;
    end
  end

  // partial mix passes on every cycle, this voice adds in its own slot when live and high
  always_ff @(posedge clk) begin
    if (fire && high) begin
      sum_out <= sum_in + cfg.voice_amp;
    end else begin
      sum_out <= sum_in;
    end
  end

endmodule

>>> test/polyphonic_square_voice_mixer_top_test.sv
`timescale 1ns / 1ps

module polyphonic_square_voice_mixer_top_test;
  import psvm_pkg::*;

  // action code with no meaning, and the register index past the last register
  localparam logic [ACTION_W-1:0]  ACT_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE   = 2'd3;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int TAIL_CYCLES     = 4 * (MAX_VOICES + 3);
  localparam int REPORT_LIMIT    = 10;
  localparam int DIR_ROWS        = 23;
  localparam int NUM_SETTINGS    = 6;

  // one result item: level, lamps, voice count
  typedef struct packed {
    logic [LEVEL_W-1:0]    level;
    logic [LAMP_COUNT-1:0] lamps;
    logic [ACTIVE_W-1:0]   voices;
  } mix_result_t;

  // directed row: the item, and a typed-in result where fixed is set
  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [KEY_W-1:0]    note;
    logic [FREQ_W-1:0]   step;
    logic                fixed;
    mix_result_t         res;
  } stim_row_t;

  // register setting for one random phase; shuffle draws fresh random values
  typedef struct packed {
    logic [PHASE_W-1:0] mask;
    logic [PHASE_W-1:0] thr;
    logic [LEVEL_W-1:0] amp;
    logic               shuffle;
  } reg_setting_t;

  typedef enum {STALL_NONE, STALL_SPARSE, STALL_COMB, STALL_HEAVY} stall_mode_t;

  // default registers throughout: mask 0xffff, threshold 0x8000, amplitude 60
  stim_row_t directed_rows [DIR_ROWS] = '{
    '{ACT_TICK,   6'd0,  16'h0000, 1'b1, {8'd0,  7'h00, 4'd0}},  // tick with an empty table
    '{ACT_UNUSED, 6'd63, 16'hffff, 1'b1, {8'd0,  7'h00, 4'd0}},  // unused code, nothing moves
    '{ACT_ADD,    6'd0,  16'hffff, 1'b1, {8'd0,  7'h01, 4'd1}},  // lowest key, lowest lamp
    '{ACT_ADD,    6'd63, 16'h0000, 1'b1, {8'd0,  7'h41, 4'd2}},  // highest key, top lamp
    '{ACT_TICK,   6'd0,  16'h0000, 1'b1, {8'd60, 7'h41, 4'd2}},  // only the 0xffff voice is high
    '{ACT_ADD,    6'd10, 16'h8000, 1'b0, 19'd0},
    '{ACT_ADD,    6'd19, 16'h4000, 1'b0, 19'd0},
    '{ACT_ADD,    6'd28, 16'h0001, 1'b0, 19'd0},
    '{ACT_ADD,    6'd37, 16'h7fff, 1'b0, 19'd0},
    '{ACT_ADD,    6'd46, 16'hc000, 1'b0, 19'd0},
    '{ACT_ADD,    6'd55, 16'h2345, 1'b1, {8'd60, 7'h7f, 4'd8}},  // table now full, all lamps lit
    '{ACT_ADD,    6'd5,  16'h1234, 1'b1, {8'd60, 7'h7f, 4'd8}},  // add to a full table is dropped
    '{ACT_TICK,   6'd0,  16'h0000, 1'b0, 19'd0},
    '{ACT_TICK,   6'd63, 16'hffff, 1'b0, 19'd0},
    '{ACT_TICK,   6'd0,  16'h0000, 1'b0, 19'd0},
    '{ACT_UNUSED, 6'd0,  16'h0000, 1'b0, 19'd0},
    '{ACT_CLEAR,  6'd0,  16'h0000, 1'b0, 19'd0},
    '{ACT_TICK,   6'd0,  16'h0000, 1'b1, {8'd0,  7'h00, 4'd0}},  // cleared table mixes to zero
    '{ACT_ADD,    6'd20, 16'h0064, 1'b0, 19'd0},                 // reused slot keeps its phase
    '{ACT_TICK,   6'd0,  16'h0000, 1'b0, 19'd0},
    '{ACT_ADD,    6'd0,  16'h0000, 1'b0, 19'd0},
    '{ACT_CLEAR,  6'd63, 16'hffff, 1'b0, 19'd0},
    '{ACT_ADD,    6'd63, 16'hffff, 1'b0, 19'd0}
  };

  // register settings for the random phases, extremes first
  reg_setting_t reg_settings [NUM_SETTINGS] = '{
    '{32'hffff_ffff, 32'h0000_0000, 8'd255, 1'b0},  // every voice high, sum wraps
    '{32'h0000_0000, 32'hffff_ffff, 8'd0,   1'b0},  // never high
    '{32'hffff_ffff, 32'h8000_0000, 8'd1,   1'b0},
    '{32'h0000_ffff, 32'h0000_8000, 8'd60,  1'b0},  // reset values again
    '{32'h0000_03ff, 32'h0000_0200, 8'd37,  1'b0},  // short period, fast toggling
    '{32'h0000_0000, 32'h0000_0000, 8'd0,   1'b1}
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [ACTION_W-1:0]   action;
  logic [KEY_W-1:0]      key;
  logic [FREQ_W-1:0]     frequency;
  logic                  out_valid;
  logic                  out_stall;
  logic [LEVEL_W-1:0]    pwm_level;
  logic [LAMP_COUNT-1:0] lamp_mask;
  logic [ACTIVE_W-1:0]   active_voices;

  polyphonic_square_voice_mixer_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .key           (key),
    .frequency     (frequency),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pwm_level     (pwm_level),
    .lamp_mask     (lamp_mask),
    .active_voices (active_voices)
  );

  // mirror of the voice table and registers
  logic [FREQ_W-1:0]     step_tbl  [MAX_VOICES];
  logic [PHASE_W-1:0]    phase_tbl [MAX_VOICES];
  int unsigned           voice_total;
  logic [LAMP_COUNT-1:0] lamp_bits;
  logic [LEVEL_W-1:0]    held_level;
  logic [PHASE_W-1:0]    cfg_mask;
  logic [PHASE_W-1:0]    cfg_thr;
  logic [LEVEL_W-1:0]    cfg_amp;

  // results still owed by the block, oldest first
  mix_result_t expected_mix_q [$];

  int unsigned burst_left;
  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned results_seen;
  int unsigned tick_count;
  int unsigned add_count;
  int unsigned clear_count;
  int unsigned ignored_count;
  int unsigned settings_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // apply one item to the mirror and return the result it should give
  function automatic mix_result_t mix_item(input logic [ACTION_W-1:0] act,
                                           input logic [KEY_W-1:0] note,
                                           input logic [FREQ_W-1:0] step);
    logic [LEVEL_W-1:0] sum;
    int unsigned        lamp;
    mix_result_t        r;
    case (act)
      ACT_TICK: begin
        sum = '0;
        for (int v = 0; v < MAX_VOICES; v++) begin
          if (v < voice_total) begin
            phase_tbl[v] = phase_tbl[v] + {{(PHASE_W-FREQ_W){1'b0}}, step_tbl[v]};
            // 8-bit sum wraps on its own
            if ((phase_tbl[v] & cfg_mask) >= cfg_thr) sum = sum + cfg_amp;
          end
        end
        held_level = sum;
      end
      ACT_CLEAR: begin
        voice_total = 0;
        lamp_bits   = '0;
      end
      ACT_ADD: begin
        if (voice_total < MAX_VOICES) begin
          step_tbl[voice_total] = step;
          voice_total++;
          lamp = (32'(note) * LAMP_COUNT) / KEY_COUNT;
          if (lamp < LAMP_COUNT) lamp_bits[lamp] = 1'b1;
        end
      end
      default: ;
    endcase
    r.level  = held_level;
    r.lamps  = lamp_bits;
    r.voices = ACTIVE_W'(voice_total);
    return r;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // offer one item in the current burst, wait for it to be taken, then log what it owes
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] note,
                           input logic [FREQ_W-1:0] step, input logic fixed,
                           input mix_result_t fixed_res);
    int unsigned gap;
    int unsigned roll;
    mix_result_t predicted;
    if (burst_left == 0) begin
      roll = $urandom_range(0, 9);
      gap  = (roll < 3) ? 0 : (roll < 9) ? $urandom_range(1, 4) : $urandom_range(6, 24);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    action    <= act;
    key       <= note;
    frequency <= step;
    do @(posedge clk); while (in_stall);
    burst_left--;
    case (act)
      ACT_TICK:  tick_count++;
      ACT_CLEAR: clear_count++;
      ACT_ADD: begin
        if (voice_total >= MAX_VOICES) ignored_count++;
        else add_count++;
      end
      default:   ignored_count++;
    endcase
    predicted = mix_item(act, note, step);
    expected_mix_q.push_back(fixed ? fixed_res : predicted);
  endtask

  // stop offering items and wait for every owed result
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_mix_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_PHASE_MASK: cfg_mask = data;
      REG_HALF_THR:   cfg_thr  = data;
      REG_VOICE_AMP:  cfg_amp  = data[LEVEL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side stalls in spells, each spell with its own pattern
  initial begin : result_stall
    stall_mode_t mode;
    int unsigned span;
    int unsigned beat;
    out_stall = 1'b0;
    mode = STALL_NONE;
    span = 0;
    beat = 0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        span = $urandom_range(20, 120);
      end
      span--;
      beat++;
      case (mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_SPARSE: out_stall <= ($urandom_range(0, 2) == 0);
        STALL_COMB:   out_stall <= ((beat % 16) < 9);
        default:      out_stall <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // compare each taken result with the oldest owed one
  always @(posedge clk) begin
    mix_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_mix_q.size() == 0) begin
        note_failure($sformatf("result with nothing owed: level %0d lamps %02h voices %0d",
                               pwm_level, lamp_mask, active_voices));
      end else begin
        want = expected_mix_q.pop_front();
        if (pwm_level !== want.level)
          note_failure($sformatf("pwm_level expected %0d got %0d", want.level, pwm_level));
        if (lamp_mask !== want.lamps)
          note_failure($sformatf("lamp_mask expected %02h got %02h", want.lamps, lamp_mask));
        if (active_voices !== want.voices)
          note_failure($sformatf("active_voices expected %0d got %0d",
                                 want.voices, active_voices));
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d results still owed", expected_mix_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned         counted;
    int unsigned         pick;
    int unsigned         freq_sel;
    logic [ACTION_W-1:0] act;
    logic [KEY_W-1:0]    note;
    logic [FREQ_W-1:0]   step;
    logic [PHASE_W-1:0]  mask_v;
    logic [PHASE_W-1:0]  thr_v;
    logic [LEVEL_W-1:0]  amp_v;

    // every input known from time zero
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    action    = ACT_TICK;
    key       = '0;
    frequency = '0;

    // mirror starts in the reset state
    for (int v = 0; v < MAX_VOICES; v++) begin
      step_tbl[v]  = '0;
      phase_tbl[v] = '0;
    end
    voice_total    = 0;
    lamp_bits      = '0;
    held_level     = '0;
    cfg_mask       = PHASE_MASK_RST;
    cfg_thr        = HALF_THR_RST;
    cfg_amp        = VOICE_AMP_RST;
    burst_left     = 0;
    cycle_count    = 0;
    mismatch_count = 0;
    results_seen   = 0;
    tick_count     = 0;
    add_count      = 0;
    clear_count    = 0;
    ignored_count  = 0;
    settings_done  = 1;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows on the reset register values
    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].act, directed_rows[r].note, directed_rows[r].step,
                directed_rows[r].fixed, directed_rows[r].res);
    end
    drain_results();

    // random phases, one register setting each
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      mask_v = reg_settings[p].mask;
      thr_v  = reg_settings[p].thr;
      amp_v  = reg_settings[p].amp;
      if (reg_settings[p].shuffle) begin
        mask_v = $urandom;
        thr_v  = $urandom & mask_v;
        amp_v  = LEVEL_W'($urandom_range(0, 255));
      end
      write_reg(REG_PHASE_MASK, mask_v);
      write_reg(REG_HALF_THR, thr_v);
      write_reg(REG_VOICE_AMP, CFG_DATA_W'(amp_v));
      // a write past the last register must leave the others alone
      write_reg(REG_NONE, $urandom);
      settings_done++;

      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        // mostly ticks and adds so the table fills up and adds to a full table get dropped
        pick = $urandom_range(0, 99);
        act  = (pick < 50) ? ACT_TICK : (pick < 85) ? ACT_ADD :
               (pick < 94) ? ACT_CLEAR : ACT_UNUSED;
        note = KEY_W'($urandom_range(0, KEY_SPAN - 1));
        freq_sel = $urandom_range(0, 9);
        case (freq_sel)
          0:       step = '0;
          1:       step = '1;
          2:       step = FREQ_W'($urandom_range(0, 255));
          default: step = FREQ_W'($urandom_range(0, 65535));
        endcase
        // ignored items do not count towards the phase
        if (act != ACT_UNUSED && !(act == ACT_ADD && voice_total >= MAX_VOICES)) counted++;
        send_item(act, note, step, 1'b0, '0);
      end
      drain_results();
    end

    // let any stray result show itself
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d ticks, %0d adds, %0d clears and %0d ignored items over %0d settings",
             tick_count, add_count, clear_count, ignored_count, settings_done);
    $display("checked %0d results, %0d mismatches, %0d still owed",
             results_seen, mismatch_count, expected_mix_q.size());
    if (mismatch_count == 0 && expected_mix_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
